// ===== sv/pavu_pkg.sv =====
// Shared widths, register codes and payload types of the point attractor velocity update unit.
package pavu_pkg;

  // Field widths.
  localparam int unsigned POS_W  = 32;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned SQ_W   = 2 * MAG_W + 1;
  localparam int unsigned ROOT_W = 33;
  localparam int unsigned GR_W   = 48;
  localparam int unsigned K_W    = 62;
  localparam int unsigned ACC_W  = 46;
  localparam int unsigned U_W    = 17;
  localparam int unsigned M_W    = 33;
  localparam int unsigned AM_W   = 65;
  localparam int unsigned P_W    = 49;
  localparam int unsigned DV_W   = 41;

  // Pipeline depths of the iterative units.
  localparam int unsigned SQRT_STAGES = 33;
  localparam int unsigned ACC_STAGES  = ACC_W;
  localparam int unsigned UDIV_STAGES = U_W;
  localparam int unsigned SIDE_DELAY  = SQRT_STAGES + UDIV_STAGES;
  localparam int unsigned ACC_ALIGN   = SIDE_DELAY - ACC_STAGES;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL   = 3'd5;

  // Reset values and arithmetic constants.
  localparam logic [15:0]       RADIUS_RST  = 16'd3200;
  localparam logic [15:0]       TSTEP_RST   = 16'd256;
  localparam logic [13:0]       FORCE_SCALE = 14'd10000;
  localparam logic [ROOT_W-1:0] MIN_ROOT    = 33'd256;
  localparam logic [SQ_W-1:0]   MIN_SQ      = 65'd65536;
  localparam logic [AM_W-1:0]   AM_LIMIT    = 65'h1_0000_0000;
  localparam logic [M_W-1:0]    AM_CLIP     = 33'h1_0000_0001;
  localparam logic [P_W-1:0]    P_LIMIT     = 49'h1_0000_0000;
  localparam logic [DV_W-1:0]   DV_CAP      = 41'h100_0000_0000;

  // Per-axis offset magnitudes.
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } mag_t;

  // Item data that rides alongside the arithmetic.
  typedef struct packed {
    logic               pos_x;
    logic               pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [31:0] mass;
  } side_t;

endpackage

// ===== sv/pavu_front.sv =====
// Front end: offsets, squared distance and force constant in three register stages.
module pavu_front import pavu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [31:0]       vel_x,
  input  logic signed [31:0]       vel_y,
  input  logic        [31:0]       mass,
  input  logic signed [POS_W-1:0]  att_x,
  input  logic signed [POS_W-1:0]  att_y,
  input  logic        [15:0]       brush_radius,
  input  logic        [31:0]       grav_gain,
  output logic                     out_valid,
  output logic        [SQ_W-1:0]   out_sq,
  output logic        [K_W-1:0]    out_k,
  output mag_t                     out_mag,
  output side_t                    out_side
);

  logic [2:0] vld_r;

  // Stage 1 registers.
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [31:0]       vx1_r, vy1_r;
  logic        [31:0]       mass1_r;
  logic        [GR_W-1:0]   gr_r;

  // Stage 2 registers.
  logic [2*MAG_W-1:0] sx_r, sy_r;
  mag_t               mag2_r;
  side_t              side2_r;
  logic [K_W-1:0]     k2_r;

  // Stage 3 registers.
  logic [SQ_W-1:0] sq_r;
  logic [K_W-1:0]  k3_r;
  mag_t            mag3_r;
  side_t           side3_r;

  logic [DIFF_W-1:0] abs_x, abs_y;
  mag_t              mag_nxt;
  side_t             side_nxt;

  // Offset magnitudes and direction flags for stage 2.
  always_comb begin
    abs_x = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    abs_y = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    mag_nxt.mag_x  = abs_x[MAG_W-1:0];
    mag_nxt.mag_y  = abs_y[MAG_W-1:0];
    side_nxt.pos_x = !dx_r[DIFF_W-1] && (dx_r != '0);
    side_nxt.pos_y = !dy_r[DIFF_W-1] && (dy_r != '0);
    side_nxt.vel_x = vx1_r;
    side_nxt.vel_y = vy1_r;
    side_nxt.mass  = mass1_r;
  end

  // Valid bits travel with the item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= {pos_x[POS_W-1], pos_x} - {att_x[POS_W-1], att_x};
      dy_r    <= {pos_y[POS_W-1], pos_y} - {att_y[POS_W-1], att_y};
      vx1_r   <= vel_x;
      vy1_r   <= vel_y;
      mass1_r <= mass;
      gr_r    <= GR_W'(grav_gain) * GR_W'(brush_radius);

      sx_r    <= (2*MAG_W)'(mag_nxt.mag_x) * (2*MAG_W)'(mag_nxt.mag_x);
      sy_r    <= (2*MAG_W)'(mag_nxt.mag_y) * (2*MAG_W)'(mag_nxt.mag_y);
      mag2_r  <= mag_nxt;
      side2_r <= side_nxt;
      k2_r    <= K_W'(gr_r) * K_W'(FORCE_SCALE);

      sq_r    <= SQ_W'(sx_r) + SQ_W'(sy_r);
      k3_r    <= k2_r;
      mag3_r  <= mag2_r;
      side3_r <= side2_r;
    end
  end

  assign out_valid = vld_r[2];
  assign out_sq    = sq_r;
  assign out_k     = k3_r;
  assign out_mag   = mag3_r;
  assign out_side  = side3_r;

endmodule

// ===== sv/pavu_sqrt.sv =====
// Pipelined integer square root of the squared distance, one root bit per stage.
module pavu_sqrt import pavu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);

  localparam int unsigned RAD_W = 2 * SQRT_STAGES;
  localparam int unsigned REM_W = ROOT_W + 3;

  logic [SQRT_STAGES-1:0] vld_r;
  logic [RAD_W-1:0]  rad_r    [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r    [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r   [SQRT_STAGES];
  logic [REM_W-1:0]  rem_nxt  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_nxt [SQRT_STAGES];

  // One digit pair per stage, most significant pair first.
  always_comb begin
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rad_in  = {1'b0, in_sq};
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
      end
      cand  = {rem_in, rad_in[2*(SQRT_STAGES-1-k) +: 2]};
      trial = (REM_W+2)'({root_in, 2'b01});
      if (cand >= trial) begin
        rem_nxt[k]  = REM_W'(cand - trial);
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = REM_W'(cand);
        root_nxt[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SQRT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r[0] <= {1'b0, in_sq};
      for (int k = 1; k < SQRT_STAGES; k++) begin
        rad_r[k] <= rad_r[k-1];
      end
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];

endmodule

// ===== sv/pavu_acc_div.sv =====
// Pipelined restoring divider for the acceleration, one quotient bit per stage.
module pavu_acc_div import pavu_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [K_W-1:0]   in_k,
  input  logic [SQ_W-1:0]  in_sq,
  output logic [ACC_W-1:0] out_acc
);

  logic [ACC_W-1:0] num_r  [ACC_STAGES];
  logic [SQ_W-1:0]  den_r  [ACC_STAGES];
  logic [SQ_W-1:0]  rem_r  [ACC_STAGES];
  logic [ACC_W-1:0] quo_r  [ACC_STAGES];
  logic [SQ_W-1:0]  rem_nxt [ACC_STAGES];
  logic [ACC_W-1:0] quo_nxt [ACC_STAGES];
  logic [SQ_W-1:0]  den_in0;

  // The distance is never taken below one unit.
  assign den_in0 = (in_sq < MIN_SQ) ? MIN_SQ : in_sq;

  // The quotient stays below 2^46, so the top dividend bits seed the remainder.
  always_comb begin
    logic [ACC_W-1:0] num_in;
    logic [SQ_W-1:0]  den_in;
    logic [SQ_W-1:0]  rem_in;
    logic [ACC_W-1:0] quo_in;
    logic [SQ_W:0]    cand;
    for (int k = 0; k < ACC_STAGES; k++) begin
      if (k == 0) begin
        num_in = in_k[ACC_W-1:0];
        den_in = den_in0;
        rem_in = SQ_W'(in_k[K_W-1:ACC_W]);
        quo_in = '0;
      end else begin
        num_in = num_r[k-1];
        den_in = den_r[k-1];
        rem_in = rem_r[k-1];
        quo_in = quo_r[k-1];
      end
      cand = {rem_in, num_in[ACC_W-1-k]};
      if (cand >= {1'b0, den_in}) begin
        rem_nxt[k] = SQ_W'(cand - {1'b0, den_in});
        quo_nxt[k] = {quo_in[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = SQ_W'(cand);
        quo_nxt[k] = {quo_in[ACC_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r[0] <= in_k[ACC_W-1:0];
      den_r[0] <= den_in0;
      for (int k = 1; k < ACC_STAGES; k++) begin
        num_r[k] <= num_r[k-1];
        den_r[k] <= den_r[k-1];
      end
      for (int k = 0; k < ACC_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign out_acc = quo_r[ACC_STAGES-1];

endmodule

// ===== sv/pavu_unit_div.sv =====
// Pipelined two-lane divider for the unit offset |d| * 2^16 / r.
module pavu_unit_div import pavu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  mag_t              in_mag,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  output logic [U_W-1:0]    out_u_x,
  output logic [U_W-1:0]    out_u_y
);

  logic [UDIV_STAGES-1:0] vld_r;
  logic [ROOT_W-1:0] den_r   [UDIV_STAGES];
  logic [U_W-1:0]    num_r   [2][UDIV_STAGES];
  logic [ROOT_W-1:0] rem_r   [2][UDIV_STAGES];
  logic [U_W-1:0]    quo_r   [2][UDIV_STAGES];
  logic [ROOT_W-1:0] rem_nxt [2][UDIV_STAGES];
  logic [U_W-1:0]    quo_nxt [2][UDIV_STAGES];
  logic [ROOT_W-1:0] den_in0;
  logic [MAG_W-1:0]  mag_in  [2];

  // The root is raised to one unit when smaller.
  assign den_in0   = (in_root < MIN_ROOT) ? MIN_ROOT : in_root;
  assign mag_in[0] = in_mag.mag_x;
  assign mag_in[1] = in_mag.mag_y;

  // The quotient is at most 2^16, so the upper numerator bits seed the remainder.
  always_comb begin
    logic [U_W-1:0]    num_in;
    logic [ROOT_W-1:0] den_in;
    logic [ROOT_W-1:0] rem_in;
    logic [U_W-1:0]    quo_in;
    logic [ROOT_W:0]   cand;
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < UDIV_STAGES; k++) begin
        if (k == 0) begin
          num_in = {mag_in[a][0], 16'd0};
          den_in = den_in0;
          rem_in = ROOT_W'(mag_in[a][MAG_W-1:1]);
          quo_in = '0;
        end else begin
          num_in = num_r[a][k-1];
          den_in = den_r[k-1];
          rem_in = rem_r[a][k-1];
          quo_in = quo_r[a][k-1];
        end
        cand = {rem_in, num_in[U_W-1-k]};
        if (cand >= {1'b0, den_in}) begin
          rem_nxt[a][k] = ROOT_W'(cand - {1'b0, den_in});
          quo_nxt[a][k] = {quo_in[U_W-2:0], 1'b1};
        end else begin
          rem_nxt[a][k] = ROOT_W'(cand);
          quo_nxt[a][k] = {quo_in[U_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[UDIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= den_in0;
      for (int k = 1; k < UDIV_STAGES; k++) begin
        den_r[k] <= den_r[k-1];
      end
      for (int a = 0; a < 2; a++) begin
        num_r[a][0] <= {mag_in[a][0], 16'd0};
        for (int k = 1; k < UDIV_STAGES; k++) begin
          num_r[a][k] <= num_r[a][k-1];
        end
        for (int k = 0; k < UDIV_STAGES; k++) begin
          rem_r[a][k] <= rem_nxt[a][k];
          quo_r[a][k] <= quo_nxt[a][k];
        end
      end
    end
  end

  assign out_valid = vld_r[UDIV_STAGES-1];
  assign out_u_x   = quo_r[0][UDIV_STAGES-1];
  assign out_u_y   = quo_r[1][UDIV_STAGES-1];

endmodule

// ===== sv/pavu_tail.sv =====
// Back end: force scaling by mass and time step, velocity update and saturation.
module pavu_tail import pavu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [U_W-1:0]     in_u_x,
  input  logic [U_W-1:0]     in_u_y,
  input  logic [ACC_W-1:0]   in_acc,
  input  side_t              in_side,
  input  logic [15:0]        time_step,
  input  logic               repel,
  output logic               out_valid,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_sat
);

  logic [3:0] vld_r;

  logic [M_W-1:0]   m_r   [2];
  side_t            side1_r;
  logic [M_W-1:0]   amc_r [2];
  side_t            side2_r;
  logic [DV_W-1:0]  dv_r  [2];
  logic             neg_r [2];
  logic signed [31:0] vel3_r [2];
  logic signed [31:0] vel_r  [2];
  logic             sat_r;

  logic [U_W-1:0]     u_in    [2];
  logic [M_W-1:0]     m_nxt   [2];
  logic [M_W-1:0]     amc_nxt [2];
  logic [DV_W-1:0]    dv_nxt  [2];
  logic signed [31:0] vel_nxt [2];
  logic               clip    [2];

  assign u_in[0] = in_u_x;
  assign u_in[1] = in_u_y;

  // Acceleration magnitude, mass product with early clipping, and time scaling.
  always_comb begin
    logic [U_W+ACC_W-1:0] prod;
    logic [AM_W-1:0]      am;
    logic [P_W-1:0]       p;
    for (int a = 0; a < 2; a++) begin
      prod       = (U_W+ACC_W)'(u_in[a]) * (U_W+ACC_W)'(in_acc);
      m_nxt[a]   = prod[U_W+ACC_W-1:30];
      am         = AM_W'(m_r[a]) * AM_W'(side1_r.mass);
      amc_nxt[a] = (am > AM_LIMIT) ? AM_CLIP : am[M_W-1:0];
      p          = P_W'(amc_r[a]) * P_W'(time_step);
      dv_nxt[a]  = (p > P_LIMIT) ? DV_CAP : {p[32:0], 8'd0};
    end
  end

  // Velocity update with clamping to the signed 32-bit range.
  always_comb begin
    logic signed [42:0] base;
    logic signed [42:0] delta;
    logic signed [42:0] sum;
    for (int a = 0; a < 2; a++) begin
      base  = 43'(vel3_r[a]);
      delta = 43'(dv_r[a]);
      sum   = neg_r[a] ? (base - delta) : (base + delta);
      clip[a] = (sum[42:31] != '0) && (sum[42:31] != '1);
      if (clip[a]) begin
        vel_nxt[a] = sum[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        vel_nxt[a] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r   <= in_side;
      side2_r   <= side1_r;
      neg_r[0]  <= side2_r.pos_x ^ repel;
      neg_r[1]  <= side2_r.pos_y ^ repel;
      vel3_r[0] <= side2_r.vel_x;
      vel3_r[1] <= side2_r.vel_y;
      for (int a = 0; a < 2; a++) begin
        m_r[a]   <= m_nxt[a];
        amc_r[a] <= amc_nxt[a];
        dv_r[a]  <= dv_nxt[a];
        vel_r[a] <= vel_nxt[a];
      end
      sat_r <= clip[0] || clip[1];
    end
  end

  assign out_valid = vld_r[3];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_sat   = sat_r;

endmodule

// ===== sv/point_attractor_velocity_update_unit.sv =====
// Top level of the point attractor velocity update unit: registers, alignment and stall control.
//
//   Port group   Direction   Handshake            Payload
//   in_*         input       in_valid / in_stall  pos_x, pos_y, vel_x, vel_y, mass
//   out_*        output      out_valid/out_stall  new_vel_x, new_vel_y, saturated
//   cfg_*        input       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle unless the pipeline is held; the depth of its path is set by
// the 33-stage square root followed by the 17-stage unit divider, plus 3 front and
// 4 back stages. Reset clears valid bits and loads the register defaults.
// The whole pipeline, bubbles included, holds while a result waits at a stalled output;
// a stall has no effect while no result is presented.
// Configuration writes are taken every cycle.
module point_attractor_velocity_update_unit import pavu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_pos_x,
  input  logic signed [31:0]       in_pos_y,
  input  logic signed [31:0]       in_vel_x,
  input  logic signed [31:0]       in_vel_y,
  input  logic        [31:0]       in_mass,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_new_vel_x,
  output logic signed [31:0]       out_new_vel_y,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]              cfg_data
);

  logic signed [31:0] att_x_r, att_y_r;
  logic [15:0]        radius_r;
  logic [31:0]        gain_r;
  logic [15:0]        tstep_r;
  logic               repel_r;

  logic adv;

  logic              fr_valid;
  logic [SQ_W-1:0]   fr_sq;
  logic [K_W-1:0]    fr_k;
  mag_t              fr_mag;
  side_t             fr_side;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [ACC_W-1:0]  acc_raw;

  logic              ud_valid;
  logic [U_W-1:0]    ud_u_x, ud_u_y;

  mag_t             mag_dly_r  [SQRT_STAGES];
  side_t            side_dly_r [SIDE_DELAY];
  logic [ACC_W-1:0] acc_dly_r  [ACC_ALIGN];

  // Pipeline moves unless a result is held at a stalled output.
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_x_r  <= '0;
      att_y_r  <= '0;
      radius_r <= RADIUS_RST;
      gain_r   <= '0;
      tstep_r  <= TSTEP_RST;
      repel_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ATT_X:  att_x_r  <= cfg_data;
        REG_ATT_Y:  att_y_r  <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[15:0];
        REG_GAIN:   gain_r   <= cfg_data;
        REG_TSTEP:  tstep_r  <= cfg_data[15:0];
        REG_REPEL:  repel_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pavu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .vel_x        (in_vel_x),
    .vel_y        (in_vel_y),
    .mass         (in_mass),
    .att_x        (att_x_r),
    .att_y        (att_y_r),
    .brush_radius (radius_r),
    .grav_gain    (gain_r),
    .out_valid    (fr_valid),
    .out_sq       (fr_sq),
    .out_k        (fr_k),
    .out_mag      (fr_mag),
    .out_side     (fr_side)
  );

  pavu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_sq     (fr_sq),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  pavu_acc_div u_acc_div (
    .clk     (clk),
    .adv     (adv),
    .in_k    (fr_k),
    .in_sq   (fr_sq),
    .out_acc (acc_raw)
  );

  // Delay lines that keep side data aligned with the root and quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_dly_r[0]  <= fr_mag;
      side_dly_r[0] <= fr_side;
      acc_dly_r[0]  <= acc_raw;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        mag_dly_r[k] <= mag_dly_r[k-1];
      end
      for (int k = 1; k < SIDE_DELAY; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
      for (int k = 1; k < ACC_ALIGN; k++) begin
        acc_dly_r[k] <= acc_dly_r[k-1];
      end
    end
  end

  pavu_unit_div u_unit_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_mag    (mag_dly_r[SQRT_STAGES-1]),
    .in_root   (sq_root),
    .out_valid (ud_valid),
    .out_u_x   (ud_u_x),
    .out_u_y   (ud_u_y)
  );

  pavu_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (ud_valid),
    .in_u_x    (ud_u_x),
    .in_u_y    (ud_u_y),
    .in_acc    (acc_dly_r[ACC_ALIGN-1]),
    .in_side   (side_dly_r[SIDE_DELAY-1]),
    .time_step (tstep_r),
    .repel     (repel_r),
    .out_valid (out_valid),
    .out_vel_x (out_new_vel_x),
    .out_vel_y (out_new_vel_y),
    .out_sat   (out_saturated)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the point attractor velocity update unit, with a predictor.
`timescale 1ns / 100ps

module tb_top;
  import pavu_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [31:0] mass;
  } particle_t;

  typedef struct {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               sat;
  } new_vel_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [127:0] SQ_OVERFLOW = 128'h1_0000_0000_0000_0000;
  localparam logic [127:0] CAP_40 = 128'h100_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic [31:0] in_mass = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_new_vel_x;
  logic signed [31:0] out_new_vel_y;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic signed [31:0] att_x_q = '0;
  logic signed [31:0] att_y_q = '0;
  logic [15:0] radius_q = RADIUS_RST;
  logic [31:0] gain_q = '0;
  logic [15:0] tstep_q = TSTEP_RST;
  logic repel_q = 1'b0;

  particle_t pending_particles[$];
  new_vel_t expected_vel[$];
  particle_t driven_particle;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  bit quiet = 0;

  point_attractor_velocity_update_unit dut (.*);

  always #10 clk = ~clk;

  // Integer square root, rounded down.
  function automatic logic [127:0] floor_root(logic [127:0] s);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  // Updated velocity along one axis, with saturation of the sum.
  function automatic logic signed [31:0] axis_velocity(longint d, logic [127:0] acc,
      logic [127:0] r, logic [31:0] mass, logic signed [31:0] vel, inout logic sat);
    logic [127:0] mag, u, m, am, mult, dv;
    longint v;
    logic neg;
    mag = 128'(d < 0 ? -d : d);
    u = (mag << 16) / r;
    m = (u * acc) >> 30;
    am = m * mass;
    mult = 128'(tstep_q) << 8;
    if (mult == 0 || am == 0) dv = '0;
    else if (am > CAP_40 / mult) dv = CAP_40;
    else dv = am * mult;
    neg = (d > 0) ^ repel_q;
    v = neg ? longint'(vel) - longint'(dv) : longint'(vel) + longint'(dv);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1'b1;
    end
    return v[31:0];
  endfunction

  // Expected updated velocity of one particle under the current settings.
  function automatic new_vel_t predict_velocity(particle_t p);
    longint dx, dy;
    logic [127:0] ax, ay, s, r, k, acc;
    new_vel_t res;
    dx = longint'(p.pos_x) - longint'(att_x_q);
    dy = longint'(p.pos_y) - longint'(att_y_q);
    ax = 128'(dx < 0 ? -dx : dx);
    ay = 128'(dy < 0 ? -dy : dy);
    s = ax * ax + ay * ay;
    r = floor_root(s);
    if (r < 128'd256) r = 128'd256;
    k = 128'(gain_q) * 128'd10000 * 128'(radius_q);
    if (s >= SQ_OVERFLOW) acc = '0;
    else acc = k / (s < 128'd65536 ? 128'd65536 : s);
    res.sat = 1'b0;
    res.vel_x = axis_velocity(dx, acc, r, p.mass, p.vel_x, res.sat);
    res.vel_y = axis_velocity(dy, acc, r, p.mass, p.vel_y, res.sat);
    return res;
  endfunction

  // Input driver: random gaps between items, payload held while stalled.
  always @(posedge clk) begin
    bit take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_vel.push_back(predict_velocity(driven_particle));
      if (!in_valid || !in_stall) begin
        take = 0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_particles.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(0, 4);
          else take = 1;
        end
        if (take) begin
          driven_particle = pending_particles.pop_front();
          in_pos_x <= driven_particle.pos_x;
          in_pos_y <= driven_particle.pos_y;
          in_vel_x <= driven_particle.vel_x;
          in_vel_y <= driven_particle.vel_y;
          in_mass <= driven_particle.mass;
        end
        in_valid <= take;
      end
    end
  end

  // Result monitor and output stall generator.
  always @(posedge clk) begin
    new_vel_t exp_v;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vel.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h %b",
            out_new_vel_x, out_new_vel_y, out_saturated);
        end else begin
          exp_v = expected_vel.pop_front();
          if (out_new_vel_x !== exp_v.vel_x || out_new_vel_y !== exp_v.vel_y ||
              out_saturated !== exp_v.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %b, got %h %h %b", exp_v.vel_x,
                exp_v.vel_y, exp_v.sat, out_new_vel_x, out_new_vel_y, out_saturated);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ATT_X:  att_x_q = data;
      REG_ATT_Y:  att_y_q = data;
      REG_RADIUS: radius_q = data[15:0];
      REG_GAIN:   gain_q = data;
      REG_TSTEP:  tstep_q = data[15:0];
      REG_REPEL:  repel_q = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] ax, logic [31:0] ay, logic [15:0] rad,
      logic [31:0] gain, logic [15:0] ts, logic rep);
    cfg_write(REG_ATT_X, ax);
    cfg_write(REG_ATT_Y, ay);
    cfg_write(REG_RADIUS, {16'h0, rad});
    cfg_write(REG_GAIN, gain);
    cfg_write(REG_TSTEP, {16'h0, ts});
    cfg_write(REG_REPEL, {31'h0, rep});
  endtask

  // Block until every item has been sent and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (pending_particles.size() > 0 || expected_vel.size() > 0 || in_valid);
    repeat (64) @(posedge clk);
  endtask

  function automatic logic [31:0] spread();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic void add_particle(logic [31:0] px, logic [31:0] py,
      logic [31:0] vx, logic [31:0] vy, logic [31:0] m);
    particle_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.vel_x = vx;
    p.vel_y = vy;
    p.mass = m;
    pending_particles.push_back(p);
  endfunction

  // Mostly particles near the attractor, where the force is meaningful.
  function automatic void add_random_particle();
    logic [31:0] px, py, vx, vy;
    if ($urandom_range(0, 4) == 0) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = att_x_q + (spread() >>> $urandom_range(0, 12));
      py = att_y_q + (spread() >>> $urandom_range(0, 12));
    end
    vx = ($urandom_range(0, 9) == 0) ? {$urandom_range(0, 1) == 1, {31{$urandom_range(0, 1) == 1}}}
                                     : spread();
    vy = ($urandom_range(0, 9) == 0) ? 32'h7fff_ffff : spread();
    add_particle(px, py, vx, vy, $urandom >> $urandom_range(0, 31));
  endfunction

  initial begin
    logic [15:0] rad, ts;
    logic [31:0] gain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: no gain, so velocities pass through.
    add_particle(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_particle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    drain();

    // Strong pull about the origin: on the attractor, very close, mid range, huge product.
    set_config(32'h0, 32'h0, 16'd32768, 32'hffff_ffff, 16'd256, 1'b0);
    add_particle(32'h0, 32'h0, 32'h1234, 32'h5678, 32'hffff_ffff);
    add_particle(32'h1, 32'hffff_ffff, 32'h0, 32'h0, 32'h1);
    add_particle(32'h0, 32'h80, 32'h0, 32'h0, 32'h1);
    add_particle(32'h10000, 32'hfff0_0000, 32'h0, 32'h0, 32'h3);
    add_particle(32'h4000, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    add_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 32'hffff_ffff);
    add_particle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h10);
    add_particle(32'h100, 32'h100, 32'h8000_0000, 32'h7fff_ffff, 32'h1);
    drain();

    // Repel mode with a small gain.
    set_config(32'h100, 32'hffff_ff00, 16'd448, 32'h0000_1000, 16'd65535, 1'b1);
    add_particle(32'h200, 32'hffff_fe00, 32'h0, 32'h0, 32'h1);
    add_particle(32'h100, 32'hffff_ff00, 32'h0, 32'h0, 32'hffff);
    add_particle(32'h0, 32'h0, 32'h7fff_0000, 32'h8001_0000, 32'h100);
    drain();

    // Far particles: attractor at the lowest corner; the first one's squared distance overflows 64 bits.
    set_config(32'h8000_0000, 32'h8000_0000, 16'd65535, 32'hffff_ffff, 16'd65535, 1'b0);
    add_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h2, 32'hffff_ffff);
    add_particle(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h2, 32'h1);
    drain();

    // Unused register indexes must leave the settings alone.
    cfg_write(3'd6, $urandom);
    cfg_write(3'd7, $urandom);

    // Random phases, each under its own settings, extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      rad = 16'($urandom_range(448, 32768));
      gain = $urandom >> $urandom_range(0, 31);
      ts = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      case (phase)
        0: begin rad = 16'd32768; gain = 32'hffff_ffff; ts = 16'd65535; end
        1: rad = 16'd0;
        2: ts = 16'd0;
        3: gain = 32'h0;
        4: rad = 16'd65535;
        default: ;
      endcase
      set_config(spread(), spread(), rad, gain, ts, 1'($urandom_range(0, 1)));
      quiet = (phase == 7);
      for (int n = 0; n < 128; n++) add_random_particle();
      drain();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_vel.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pavu_pkg.sv
sv/pavu_front.sv
sv/pavu_sqrt.sv
sv/pavu_acc_div.sv
sv/pavu_unit_div.sv
sv/pavu_tail.sv
sv/point_attractor_velocity_update_unit.sv
sim/tb_top.sv
